FILE: rtl/bpq_pkg.sv
// Buzzer pattern queue: shared types, constants and controller states.
// No dependencies; imported by every module of the block except bpq_ram.
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

	// Default queue depth, handed to the top-level parameter
	localparam int QUEUE_DEPTH_DEF = 4;

	// Field widths
	localparam int TOTAL_W  = 16;
	localparam int PHASE_W  = 8;
	localparam int PERIOD_W = 10;

	// Operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_ENQUEUE = 1'b1;

	// Input beat
	typedef struct packed {
		logic               op;
		logic [TOTAL_W-1:0] total_ticks;
		logic [PHASE_W-1:0] first_on;
		logic [PHASE_W-1:0] first_off;
		logic [PHASE_W-1:0] second_on;
		logic [PHASE_W-1:0] second_off;
	} in_beat_t;

	// Result beat
	typedef struct packed {
		logic buzzer_level;
		logic enqueue_accepted;
		logic pattern_finished;
		logic queue_full;
		logic queue_empty;
	} out_beat_t;

	// One stored pattern
	typedef struct packed {
		logic [TOTAL_W-1:0]  total;
		logic [PHASE_W-1:0]  on1;
		logic [PHASE_W-1:0]  off1;
		logic [PHASE_W-1:0]  on2;
		logic [PHASE_W-1:0]  off2;
		logic [PERIOD_W-1:0] period;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic enq;   // store the input pattern
		logic tick;  // advance the head pattern by one tick
		logic hold;  // report state unchanged (tick on an empty queue)
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/bpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/bpq_ctrl.sv
// Buzzer pattern queue controller: sequences accept, head read, update, result.
// Depends on bpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpq_ctrl
	import bpq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     in_op,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire logic     has_pattern,
	output cmd_t          cmd
);

	state_t state_q, state_nx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands
	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_ENQUEUE) begin
						cmd.enq  = 1'b1;
						state_nx = ST_OUT;
					end else if (has_pattern) begin
						// head entry is read this cycle, used next cycle
						state_nx = ST_TICK;
					end else begin
						cmd.hold = 1'b1;
						state_nx = ST_OUT;
					end
				end
			end
			ST_TICK: begin
				cmd.tick = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/bpq_dp.sv
// Buzzer pattern queue datapath: queue pointers, pattern RAM, phase logic, result.
// Depends on bpq_pkg and bpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bpq_dp
	import bpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      cmd,
	input  wire in_beat_t  in_data,
	output logic           has_pattern,
	output out_beat_t      out_data
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic [IDX_W-1:0]    head_q, head_nx, tail_q, tail_nx;
	logic                full_q, full_nx;
	logic [TOTAL_W-1:0]  elapsed_q, elapsed_nx;
	logic [PERIOD_W-1:0] phase_q, phase_nx;
	logic                drive_q, drive_nx;
	out_beat_t           res_q, res_nx;

	entry_t              wr_entry, rd_entry;
	logic                ram_we;
	logic                accepted, finished;

	logic [PHASE_W:0]    first_len;
	logic [PERIOD_W-1:0] second_end;
	logic [PERIOD_W:0]   phase_inc;
	logic [TOTAL_W-1:0]  elapsed_inc;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	assign has_pattern = (head_q != tail_q) || full_q;

	// Pattern to store, with its period
	always_comb begin
		wr_entry.total  = in_data.total_ticks;
		wr_entry.on1    = in_data.first_on;
		wr_entry.off1   = in_data.first_off;
		wr_entry.on2    = in_data.second_on;
		wr_entry.off2   = in_data.second_off;
		wr_entry.period = PERIOD_W'(in_data.first_on) + PERIOD_W'(in_data.first_off)
			+ PERIOD_W'(in_data.second_on) + PERIOD_W'(in_data.second_off);
	end

	// Pattern store; the head entry is read every cycle
	bpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata(wr_entry),
		.raddr(head_q),
		.rdata(rd_entry)
	);

	// Phase edge arithmetic on the head entry
	assign first_len   = {1'b0, rd_entry.on1} + {1'b0, rd_entry.off1};
	assign second_end  = PERIOD_W'(first_len) + PERIOD_W'(rd_entry.on2);
	assign phase_inc   = {1'b0, phase_q} + 1'b1;
	assign elapsed_inc = elapsed_q + 1'b1;

	// Next state for enqueue and tick
	always_comb begin
		head_nx    = head_q;
		tail_nx    = tail_q;
		full_nx    = full_q;
		elapsed_nx = elapsed_q;
		phase_nx   = phase_q;
		drive_nx   = drive_q;
		ram_we     = 1'b0;
		accepted   = 1'b0;
		finished   = 1'b0;

		if (cmd.enq) begin
			if ((in_data.total_ticks != '0) && !full_q) begin
				accepted = 1'b1;
				ram_we   = 1'b1;
				tail_nx  = next_slot(tail_q);
				full_nx  = (next_slot(tail_q) == head_q);
			end
		end

		if (cmd.tick) begin
			// level change at the phase edges
			if (phase_q < PERIOD_W'(first_len)) begin
				if (phase_q == '0) begin
					drive_nx = (rd_entry.on1 != '0);
				end else if (phase_q == PERIOD_W'(rd_entry.on1)) begin
					drive_nx = 1'b0;
				end
			end else begin
				if (phase_q == PERIOD_W'(first_len)) begin
					if (rd_entry.on2 != '0) begin
						drive_nx = 1'b1;
					end
				end else if (phase_q == second_end) begin
					drive_nx = 1'b0;
				end
			end

			// phase counter wraps at the period
			if (rd_entry.period != '0) begin
				phase_nx = (phase_inc >= {1'b0, rd_entry.period}) ? '0
					: phase_inc[PERIOD_W-1:0];
			end else begin
				phase_nx = '0;
			end

			// pattern end drops the head
			elapsed_nx = elapsed_inc;
			if (elapsed_inc >= rd_entry.total) begin
				drive_nx   = 1'b0;
				head_nx    = next_slot(head_q);
				elapsed_nx = '0;
				phase_nx   = '0;
				full_nx    = 1'b0;
				finished   = 1'b1;
			end
		end
	end

	// Result of this item
	always_comb begin
		res_nx.buzzer_level     = drive_nx;
		res_nx.enqueue_accepted = accepted;
		res_nx.pattern_finished = finished;
		res_nx.queue_full       = full_nx;
		res_nx.queue_empty      = !((head_nx != tail_nx) || full_nx);
	end

	// Queue and player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			full_q    <= 1'b0;
			elapsed_q <= '0;
			phase_q   <= '0;
			drive_q   <= 1'b0;
		end else begin
			head_q    <= head_nx;
			tail_q    <= tail_nx;
			full_q    <= full_nx;
			elapsed_q <= elapsed_nx;
			phase_q   <= phase_nx;
			drive_q   <= drive_nx;
		end
	end

	// Result register, held while the receiver stalls
	always_ff @(posedge clk) begin
		if (cmd.enq || cmd.tick || cmd.hold) begin
			res_q <= res_nx;
		end
	end

	assign out_data = res_q;

endmodule

`default_nettype wire

FILE: rtl/buzzer_pattern_queue_unit.sv
// Buzzer pattern queue top level: controller plus datapath.
// Depends on bpq_pkg, bpq_ctrl, bpq_dp (and bpq_ram through bpq_dp).
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one beat per item:
//   op = enqueue stores a pattern at the queue tail; op = tick advances the
//   head pattern by one time tick. Output channel (out_valid/out_ready/
//   out_data) returns exactly one result beat per input beat, in order.
//   An enqueue, or a tick on an empty queue, shows its result in the cycle
//   after acceptance; a tick on a busy queue passes through ST_TICK first,
//   since the head pattern is fetched from the registered-read pattern RAM.
//   Items are taken one at a time: an enqueue or idle tick passes through
//   ST_IDLE and ST_OUT, a playing tick through ST_IDLE, ST_TICK, ST_OUT.
//   A stalled receiver holds the result beat and keeps in_ready low.
//   Reset (arst_n low) empties the queue, turns the buzzer off and clears
//   the phase and elapsed counters; the pattern RAM needs no clearing since
//   an entry is read only after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_pattern_queue_unit
	import bpq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_beat_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_beat_t     out_data
);

	cmd_t cmd;
	logic has_pattern;

	bpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_op      (in_data.op),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.has_pattern(has_pattern),
		.cmd        (cmd)
	);

	bpq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_data    (in_data),
		.has_pattern(has_pattern),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire
